FILE: rtl/imf3_pkg.sv
// ----------------------------------------------------------------------------
// imf3_pkg
// shared types and constants of the 3x3 image filter
// ----------------------------------------------------------------------------
package imf3_pkg;

	typedef logic [7:0] pix_t;
	typedef pix_t [8:0] win_t;

	localparam logic [1:0] MODE_MEAN   = 2'd0;
	localparam logic [1:0] MODE_MEDIAN = 2'd1;

	localparam logic [1:0] REG_MODE = 2'd0;
	localparam logic [1:0] REG_ROWS = 2'd1;
	localparam logic [1:0] REG_COLS = 2'd2;

	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	// ceil(65536 / 9), exact floor(sum / 9) for sums up to 9 * 255
	localparam logic [12:0] RECIP9 = 13'd7282;

	typedef enum logic [3:0] {
		C_IDLE,
		C_SHIFT,
		C_LOAD,
		C_START,
		C_RUN,
		C_OUT,
		C_D0,
		C_D1,
		C_D2
	} ctrl_state_t;

	typedef enum logic [3:0] {
		F_IDLE,
		F_SUM,
		F_DIV,
		F_MED,
		F_GRAD,
		F_SQR,
		F_ADD,
		F_ROOT,
		F_DONE
	} filt_state_t;

	typedef enum logic [2:0] {
		NB_HOLD,
		NB_MAIN,
		NB_LAST,
		NB_D0,
		NB_D1,
		NB_D2
	} nb_sel_t;

	typedef struct packed {
		logic       mem_rd;
		logic       mem_wr;
		logic       px_load;
		logic       shift;
		nb_sel_t    nb_sel;
		logic       edge_r;
		logic       edge_c;
		logic [1:0] mode;
		logic       filt_start;
		logic       filt_edge;
		logic       out_load;
		logic       out_eor;
		logic       out_eof;
		logic       out_last;
	} dp_cmd_t;

	typedef struct packed {
		logic filt_done;
		logic out_free;
	} dp_sts_t;

endpackage

FILE: rtl/imf3_filt.sv
// ----------------------------------------------------------------------------
// imf3_filt
// multi-cycle filter unit: mean, median and sobel magnitude of one window
// ----------------------------------------------------------------------------
module imf3_filt (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [1:0]     mode,
	input  logic           filt_edge,
	input  imf3_pkg::win_t nb,
	output logic           done,
	output imf3_pkg::pix_t result
);

	imf3_pkg::filt_state_t state_q, state_d;

	logic [11:0]        sum_d, sum_q;
	logic [24:0]        prod_d;
	logic [3:0]         k_q;
	logic [3:0]         n_lt, n_le;
	logic               found;
	imf3_pkg::pix_t     cand;
	logic [9:0]         xp, xn, yp, yn;
	logic signed [10:0] gx_d, gy_d, gx_q, gy_q;
	logic [9:0]         ax, ay;
	logic [19:0]        sqx_q, sqy_q;
	logic [20:0]        s_q;
	logic [2:0]         step_q;
	logic [7:0]         root_q, bit_d, t_d, root_d;
	logic [15:0]        tt_d;
	logic               copy;
	imf3_pkg::pix_t     result_q;

	assign copy = (mode == imf3_pkg::MODE_MEAN || mode == imf3_pkg::MODE_MEDIAN) && filt_edge;

	always_comb begin
		sum_d = '0;
		for (int m = 0; m < 9; m++) begin
			sum_d = sum_d + 12'(nb[m]);
		end
		prod_d = 25'(sum_q) * 25'(imf3_pkg::RECIP9);
	end

	// rank test of one candidate against all nine pixels
	always_comb begin
		cand = nb[k_q];
		n_lt = '0;
		n_le = '0;
		for (int m = 0; m < 9; m++) begin
			n_lt = n_lt + 4'(nb[m] < cand);
			n_le = n_le + 4'(nb[m] <= cand);
		end
		found = (n_lt <= 4'd4) && (n_le >= 4'd5);
	end

	always_comb begin
		xp = 10'(nb[2]) + 10'({nb[5], 1'b0}) + 10'(nb[8]);
		xn = 10'(nb[0]) + 10'({nb[3], 1'b0}) + 10'(nb[6]);
		yp = 10'(nb[6]) + 10'({nb[7], 1'b0}) + 10'(nb[8]);
		yn = 10'(nb[0]) + 10'({nb[1], 1'b0}) + 10'(nb[2]);
		gx_d = $signed({1'b0, xp}) - $signed({1'b0, xn});
		gy_d = $signed({1'b0, yp}) - $signed({1'b0, yn});
		ax = gx_q[10] ? 10'(-gx_q) : gx_q[9:0];
		ay = gy_q[10] ? 10'(-gy_q) : gy_q[9:0];
	end

	// one result bit per step
	always_comb begin
		bit_d  = 8'h80 >> step_q;
		t_d    = root_q | bit_d;
		tt_d   = 16'(t_d) * 16'(t_d);
		root_d = (tt_d <= s_q[15:0]) ? t_d : root_q;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			imf3_pkg::F_IDLE: begin
				if (start) begin
					if (copy)
						state_d = imf3_pkg::F_DONE;
					else if (mode == imf3_pkg::MODE_MEAN)
						state_d = imf3_pkg::F_SUM;
					else if (mode == imf3_pkg::MODE_MEDIAN)
						state_d = imf3_pkg::F_MED;
					else
						state_d = imf3_pkg::F_GRAD;
				end
			end
			imf3_pkg::F_SUM:  state_d = imf3_pkg::F_DIV;
			imf3_pkg::F_DIV:  state_d = imf3_pkg::F_DONE;
			imf3_pkg::F_MED:  if (found || k_q == 4'd8) state_d = imf3_pkg::F_DONE;
			imf3_pkg::F_GRAD: state_d = imf3_pkg::F_SQR;
			imf3_pkg::F_SQR:  state_d = imf3_pkg::F_ADD;
			imf3_pkg::F_ADD:  state_d = imf3_pkg::F_ROOT;
			imf3_pkg::F_ROOT: begin
				if (s_q[20:16] != '0 || step_q == 3'd7) state_d = imf3_pkg::F_DONE;
			end
			imf3_pkg::F_DONE: state_d = imf3_pkg::F_IDLE;
			default:          state_d = imf3_pkg::F_IDLE;
		endcase
	end

	always_comb begin
		done   = (state_q == imf3_pkg::F_DONE);
		result = result_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= imf3_pkg::F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			imf3_pkg::F_IDLE: begin
				k_q    <= '0;
				step_q <= '0;
				root_q <= '0;
				if (start && copy) result_q <= nb[4];
			end
			imf3_pkg::F_SUM: sum_q <= sum_d;
			imf3_pkg::F_DIV: result_q <= prod_d[23:16];
			imf3_pkg::F_MED: begin
				if (found) result_q <= cand;
				k_q <= k_q + 4'd1;
			end
			imf3_pkg::F_GRAD: begin
				gx_q <= gx_d;
				gy_q <= gy_d;
			end
			imf3_pkg::F_SQR: begin
				sqx_q <= 20'(ax) * 20'(ax);
				sqy_q <= 20'(ay) * 20'(ay);
			end
			imf3_pkg::F_ADD: s_q <= 21'(sqx_q) + 21'(sqy_q);
			imf3_pkg::F_ROOT: begin
				root_q <= root_d;
				step_q <= step_q + 3'd1;
				if (s_q[20:16] != '0)
					result_q <= 8'hff;
				else if (step_q == 3'd7)
					result_q <= root_d;
			end
			imf3_pkg::F_DONE: ;
			default: ;
		endcase
	end

endmodule

FILE: rtl/imf3_dpath.sv
// ----------------------------------------------------------------------------
// imf3_dpath
// line stores, 3x3 window, neighborhood register, filter and output word
// ----------------------------------------------------------------------------
module imf3_dpath #(
	parameter int MAX_COLS = 2048
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  imf3_pkg::dp_cmd_t           cmd,
	input  logic [$clog2(MAX_COLS)-1:0] addr,
	input  imf3_pkg::pix_t              in_pixel,
	input  logic                        out_ready,
	output imf3_pkg::dp_sts_t           sts,
	output logic                        out_valid,
	output imf3_pkg::pix_t              out_pixel,
	output logic                        out_eor,
	output logic                        out_eof,
	output logic                        out_last
);

	imf3_pkg::pix_t up_mem [MAX_COLS];
	imf3_pkg::pix_t lo_mem [MAX_COLS];
	imf3_pkg::pix_t up_rd_q, lo_rd_q, px_q;
	imf3_pkg::win_t win_q, nb_q, nb_main, nb_last;
	imf3_pkg::pix_t filt_res;
	logic           filt_done;
	logic           out_valid_q;
	imf3_pkg::pix_t out_pixel_q;
	logic           out_eor_q, out_eof_q, out_last_q;

	always_ff @(posedge clk) begin
		if (cmd.mem_wr) begin
			up_mem[addr] <= lo_rd_q;
			lo_mem[addr] <= px_q;
		end
		if (cmd.mem_rd) begin
			up_rd_q <= up_mem[addr];
			lo_rd_q <= lo_mem[addr];
		end
	end

	// neighborhood picks with rows and columns mirrored at the edges
	always_comb begin
		int rs0, cs0, ra, cm, cl;
		rs0 = cmd.edge_r ? 2 : 0;
		cs0 = cmd.edge_c ? 2 : 0;
		for (int a = 0; a < 3; a++) begin
			for (int b = 0; b < 3; b++) begin
				ra = (a == 0) ? rs0 : a;
				cm = (b == 0) ? cs0 : b;
				cl = (b == 1) ? 2 : 1;
				nb_main[a*3+b] = win_q[ra*3+cm];
				nb_last[a*3+b] = win_q[ra*3+cl];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.px_load) px_q <= in_pixel;
		if (cmd.shift) begin
			for (int k = 0; k < 3; k++) begin
				win_q[k*3+0] <= win_q[k*3+1];
				win_q[k*3+1] <= win_q[k*3+2];
			end
			win_q[2] <= up_rd_q;
			win_q[5] <= lo_rd_q;
			win_q[8] <= px_q;
		end
		unique case (cmd.nb_sel)
			imf3_pkg::NB_MAIN: nb_q <= nb_main;
			imf3_pkg::NB_LAST: nb_q <= nb_last;
			imf3_pkg::NB_D0: begin
				nb_q[0] <= up_rd_q;
				nb_q[3] <= lo_rd_q;
				nb_q[6] <= up_rd_q;
			end
			imf3_pkg::NB_D1: begin
				nb_q[1] <= up_rd_q;
				nb_q[4] <= lo_rd_q;
				nb_q[7] <= up_rd_q;
			end
			imf3_pkg::NB_D2: begin
				nb_q[2] <= up_rd_q;
				nb_q[5] <= lo_rd_q;
				nb_q[8] <= up_rd_q;
			end
			imf3_pkg::NB_HOLD: ;
			default: ;
		endcase
	end

	imf3_filt u_filt (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.filt_start),
		.mode      (cmd.mode),
		.filt_edge (cmd.filt_edge),
		.nb        (nb_q),
		.done      (filt_done),
		.result    (filt_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_pixel_q <= filt_res;
			out_eor_q   <= cmd.out_eor;
			out_eof_q   <= cmd.out_eof;
			out_last_q  <= cmd.out_last;
		end
	end

	assign sts.filt_done = filt_done;
	assign sts.out_free  = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign out_pixel     = out_pixel_q;
	assign out_eor       = out_eor_q;
	assign out_eof       = out_eof_q;
	assign out_last      = out_last_q;

endmodule

FILE: rtl/imf3_ctrl.sv
// ----------------------------------------------------------------------------
// imf3_ctrl
// sequencer, raster counters and configuration registers
// ----------------------------------------------------------------------------
module imf3_ctrl #(
	parameter int MAX_COLS = 2048,
	parameter int MAX_ROWS = 4096
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_command,
	output logic                        in_ready,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [12:0]                 cfg_data,
	input  imf3_pkg::dp_sts_t           sts,
	output imf3_pkg::dp_cmd_t           cmd,
	output logic [$clog2(MAX_COLS)-1:0] addr
);

	localparam int CIDX_W = $clog2(MAX_COLS);
	localparam int RIDX_W = $clog2(MAX_ROWS);
	localparam int CCNT_W = $clog2(MAX_COLS + 1);
	localparam int RCNT_W = $clog2(MAX_ROWS + 1);

	imf3_pkg::ctrl_state_t state_q, state_d;

	logic [1:0]        mode_q;
	logic [12:0]       rows_q;
	logic [11:0]       cols_q;
	logic [31:0]       rows32, cols32;
	logic [RCNT_W-1:0] rows;
	logic [CCNT_W-1:0] cols;
	logic [RIDX_W-1:0] row_last, in_row_q;
	logic [CIDX_W-1:0] col_last, col_pen, in_col_q, drain_col_q, d_left, d_right;
	logic              draining_q;
	logic              accept, take_px, take_drain;
	logic              edge_r_q, edge_c_q, second_q, phase_q, is_drain_q, dlast_q;
	logic              produce;

	assign rows32   = 32'(rows_q);
	assign cols32   = 32'(cols_q);
	assign rows     = (rows32 < 32'd3) ? RCNT_W'(3) :
	                  (rows32 > 32'(MAX_ROWS)) ? RCNT_W'(MAX_ROWS) : RCNT_W'(rows32);
	assign cols     = (cols32 < 32'd3) ? CCNT_W'(3) :
	                  (cols32 > 32'(MAX_COLS)) ? CCNT_W'(MAX_COLS) : CCNT_W'(cols32);
	assign row_last = RIDX_W'(rows - RCNT_W'(1));
	assign col_last = CIDX_W'(cols - CCNT_W'(1));
	assign col_pen  = CIDX_W'(cols - CCNT_W'(2));
	assign d_left   = (drain_col_q == '0) ? CIDX_W'(1) : drain_col_q - CIDX_W'(1);
	assign d_right  = (drain_col_q == col_last) ? col_pen : drain_col_q + CIDX_W'(1);

	assign accept     = in_valid && (state_q == imf3_pkg::C_IDLE);
	assign take_px    = accept && in_command == imf3_pkg::CMD_PIXEL && !draining_q;
	assign take_drain = accept && in_command == imf3_pkg::CMD_DRAIN && draining_q;
	assign produce    = (in_row_q != '0) && (in_col_q != '0);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			imf3_pkg::C_IDLE: begin
				if (take_px) state_d = imf3_pkg::C_SHIFT;
				else if (take_drain) state_d = imf3_pkg::C_D0;
			end
			imf3_pkg::C_SHIFT: state_d = produce ? imf3_pkg::C_LOAD : imf3_pkg::C_IDLE;
			imf3_pkg::C_LOAD:  state_d = imf3_pkg::C_START;
			imf3_pkg::C_START: state_d = imf3_pkg::C_RUN;
			imf3_pkg::C_RUN:   if (sts.filt_done) state_d = imf3_pkg::C_OUT;
			imf3_pkg::C_OUT: begin
				if (sts.out_free)
					state_d = (!is_drain_q && !phase_q && second_q) ?
					          imf3_pkg::C_LOAD : imf3_pkg::C_IDLE;
			end
			imf3_pkg::C_D0: state_d = imf3_pkg::C_D1;
			imf3_pkg::C_D1: state_d = imf3_pkg::C_D2;
			imf3_pkg::C_D2: state_d = imf3_pkg::C_START;
			default:        state_d = imf3_pkg::C_IDLE;
		endcase
	end

	always_comb begin
		cmd            = '0;
		cmd.nb_sel     = imf3_pkg::NB_HOLD;
		cmd.edge_r     = edge_r_q;
		cmd.edge_c     = edge_c_q;
		cmd.mode       = mode_q;
		cmd.filt_edge  = is_drain_q || phase_q || edge_r_q || edge_c_q;
		cmd.out_eor    = is_drain_q ? dlast_q : phase_q;
		cmd.out_eof    = is_drain_q && dlast_q;
		cmd.out_last   = is_drain_q || phase_q || !second_q;
		addr           = in_col_q;
		in_ready       = (state_q == imf3_pkg::C_IDLE);
		unique case (state_q)
			imf3_pkg::C_IDLE: begin
				cmd.px_load = take_px;
				cmd.mem_rd  = take_px || take_drain;
				addr        = take_drain ? d_left : in_col_q;
			end
			imf3_pkg::C_SHIFT: begin
				cmd.shift  = 1'b1;
				cmd.mem_wr = 1'b1;
			end
			imf3_pkg::C_LOAD:  cmd.nb_sel = phase_q ? imf3_pkg::NB_LAST : imf3_pkg::NB_MAIN;
			imf3_pkg::C_START: cmd.filt_start = 1'b1;
			imf3_pkg::C_RUN:   ;
			imf3_pkg::C_OUT:   cmd.out_load = sts.out_free;
			imf3_pkg::C_D0: begin
				cmd.nb_sel = imf3_pkg::NB_D0;
				cmd.mem_rd = 1'b1;
				addr       = drain_col_q;
			end
			imf3_pkg::C_D1: begin
				cmd.nb_sel = imf3_pkg::NB_D1;
				cmd.mem_rd = 1'b1;
				addr       = d_right;
			end
			imf3_pkg::C_D2:    cmd.nb_sel = imf3_pkg::NB_D2;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= imf3_pkg::C_IDLE;
			mode_q      <= imf3_pkg::MODE_MEAN;
			rows_q      <= 13'd512;
			cols_q      <= 12'd512;
			in_row_q    <= '0;
			in_col_q    <= '0;
			drain_col_q <= '0;
			draining_q  <= 1'b0;
			edge_r_q    <= 1'b0;
			edge_c_q    <= 1'b0;
			second_q    <= 1'b0;
			phase_q     <= 1'b0;
			is_drain_q  <= 1'b0;
			dlast_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we && cfg_index == imf3_pkg::REG_MODE) begin
				mode_q <= cfg_data[1:0];
			end else if (cfg_we && (cfg_index == imf3_pkg::REG_ROWS ||
			                        cfg_index == imf3_pkg::REG_COLS)) begin
				if (cfg_index == imf3_pkg::REG_ROWS) rows_q <= cfg_data;
				else cols_q <= cfg_data[11:0];
				in_row_q    <= '0;
				in_col_q    <= '0;
				drain_col_q <= '0;
				draining_q  <= 1'b0;
			end else begin
				unique case (state_q)
					imf3_pkg::C_IDLE: begin
						if (take_px) is_drain_q <= 1'b0;
						if (take_drain) begin
							is_drain_q <= 1'b1;
							phase_q    <= 1'b0;
							edge_r_q   <= 1'b0;
							edge_c_q   <= 1'b0;
							second_q   <= 1'b0;
							dlast_q    <= (drain_col_q == col_last);
						end
					end
					imf3_pkg::C_SHIFT: begin
						phase_q  <= 1'b0;
						edge_r_q <= (in_row_q == RIDX_W'(1));
						edge_c_q <= (in_col_q == CIDX_W'(1));
						second_q <= (in_col_q == col_last);
						if (in_col_q == col_last) begin
							in_col_q <= '0;
							if (in_row_q == row_last) begin
								in_row_q    <= '0;
								draining_q  <= 1'b1;
								drain_col_q <= '0;
							end else begin
								in_row_q <= in_row_q + RIDX_W'(1);
							end
						end else begin
							in_col_q <= in_col_q + CIDX_W'(1);
						end
					end
					imf3_pkg::C_OUT: begin
						if (sts.out_free) begin
							if (!is_drain_q && !phase_q && second_q) phase_q <= 1'b1;
							if (is_drain_q) begin
								if (dlast_q) begin
									drain_col_q <= '0;
									draining_q  <= 1'b0;
									in_row_q    <= '0;
									in_col_q    <= '0;
								end else begin
									drain_col_q <= drain_col_q + CIDX_W'(1);
								end
							end
						end
					end
					default: ;
				endcase
			end
		end
	end

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		CCNT_W'(in_col_q) < cols && CCNT_W'(drain_col_q) < cols)
		else $error("raster column beyond frame width");

	a_drain_origin: assert property (@(posedge clk) disable iff (!arst_n)
		draining_q |-> in_row_q == '0 && in_col_q == '0)
		else $error("input counters not at origin while draining");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("output word overwritten before taken");

	a_done_run: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == imf3_pkg::C_START |-> !sts.filt_done)
		else $error("filter busy when a new window starts");

endmodule

FILE: rtl/image_filter_3x3_unit.sv
// ----------------------------------------------------------------------------
// image_filter_3x3_unit
// streaming 3x3 mean, median or sobel filter over a raster grayscale image
// ----------------------------------------------------------------------------
// input words carry a pixel (tuser = 0) or a drain command (tuser = 1);
// pixels arrive in raster order, each output pixel (r,c) appears once input
// (r+1,c+1) is in, and the last pixel of a row follows its left neighbour
// from the same input word. after the last row of a frame is in, each drain
// word yields one final-row pixel; after the last of them a new frame starts
// one word is worked on at a time: a pixel word without result passes idle
// and shift; a word with a result goes on to load, start, run and out, the
// filter copying the centre pixel at edges in mean and median mode; median
// makes one rank test per cycle and sobel one root bit per cycle; a drain
// word reads the line stores in place of shift and load.
// tready is high only when the sequencer is idle
// a one-word output register lets the next input word be taken while the
// last result waits; a stalled receiver holds the sequencer before it would
// overwrite that word. reset clears the counters and the output valid, sets
// mean mode and a 512 x 512 frame; line stores are undefined until the first
// frame fills them. configuration writes to frame size restart the frame
// ----------------------------------------------------------------------------
module image_filter_3x3_unit #(
	parameter int MAX_COLS = 2048,
	parameter int MAX_ROWS = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // pixel
	input  logic        s_tuser,   // command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // result_pixel
	output logic        m_tlast,   // end_of_row
	output logic [1:0]  m_tuser,   // end_of_frame, last_of_item
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data
);

	// command and status between sequencer and datapath
	imf3_pkg::dp_cmd_t           cmd;
	imf3_pkg::dp_sts_t           sts;
	logic [$clog2(MAX_COLS)-1:0] addr;

	imf3_ctrl #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_command (s_tuser),
		.in_ready   (s_tready),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.sts        (sts),
		.cmd        (cmd),
		.addr       (addr)
	);

	// line stores, window and filter unit
	imf3_dpath #(
		.MAX_COLS (MAX_COLS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.addr      (addr),
		.in_pixel  (s_tdata),
		.out_ready (m_tready),
		.sts       (sts),
		.out_valid (m_tvalid),
		.out_pixel (m_tdata),
		.out_eor   (m_tlast),
		.out_eof   (m_tuser[0]),
		.out_last  (m_tuser[1])
	);

endmodule
